// ===== rtl/lcdx_pkg.sv =====
// Package for the character-LCD expander byte generator.
// Holds field widths, mode codes, control patterns, shared structs and the nibble encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcdx_pkg;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int COL_W    = 6;
    localparam int NUM_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int PIX_W    = 5;
    localparam int ROWS_N   = 8;
    localparam int ROWS_W   = PIX_W * ROWS_N;
    localparam int DIGITS   = 5;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int BITCNT_W = $clog2(NUM_W);
    localparam int DIGCNT_W = $clog2(DIGITS + 1);
    localparam int REM_W    = 4;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_CMD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CHAR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CURSOR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NUMBER = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GLYPH  = 3'd4;

    // Control-line patterns in the low nibble of an expander byte
    localparam logic [3:0] DATA_STROBE = 4'hD;
    localparam logic [3:0] DATA_HOLD   = 4'h9;
    localparam logic [3:0] CMD_STROBE  = 4'h4;
    localparam logic [3:0] CMD_HI_HOLD = 4'h0;
    localparam logic [3:0] CMD_LO_HOLD = 4'h8;

    // Display command and character bases
    localparam logic [BYTE_W-1:0] DDRAM_ROW0 = 8'h80;
    localparam logic [BYTE_W-1:0] DDRAM_ROW1 = 8'hC0;
    localparam logic [1:0]        CGRAM_TAG  = 2'b01;
    localparam logic [3:0]        ASCII_DIG  = 4'h3;

    // Number of logical bytes after the first one in a glyph request
    localparam logic [REM_W-1:0] GLYPH_REM = REM_W'(ROWS_N + 1);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } seq_state_t;

    // One expander beat offered by the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] lb;
        logic              cmd;
        logic [1:0]        phase;
        logic              last;
        logic              nr;
    } emit_t;

    // Commands to the decimal converter
    typedef struct packed {
        logic              start;
        logic              shift;
        logic [NUM_W-1:0]  value;
    } bcd_ctrl_t;

    // Status from the decimal converter
    typedef struct packed {
        logic       done;
        logic [3:0] top;
    } bcd_stat_t;

    // Expander byte for one phase of a logical byte: even phases strobe, odd phases hold.
    function automatic logic [BYTE_W-1:0] enc_byte(input logic [BYTE_W-1:0] lb,
                                                   input logic cmd,
                                                   input logic [1:0] phase);
        logic [3:0] nib;
        logic [3:0] ctl;
        nib = phase[1] ? lb[3:0] : lb[7:4];
        if (cmd)
        begin
            if (!phase[0])
                ctl = CMD_STROBE;
            else
                ctl = phase[1] ? CMD_LO_HOLD : CMD_HI_HOLD;
        end
        else
        begin
            ctl = phase[0] ? DATA_HOLD : DATA_STROBE;
        end
        return {nib, ctl};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lcdx_if.sv =====
// Channel interfaces for the request and result streams.
// Depends on lcdx_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lcdx_req_if import lcdx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] value_byte;
    logic [COL_W-1:0]  cursor_col;
    logic              cursor_row;
    logic [NUM_W-1:0]  number_value;
    logic [SLOT_W-1:0] glyph_slot;
    logic [ROWS_W-1:0] glyph_rows;

    modport source (output valid, mode, value_byte, cursor_col, cursor_row,
                    number_value, glyph_slot, glyph_rows, input ready);
    modport sink   (input valid, mode, value_byte, cursor_col, cursor_row,
                    number_value, glyph_slot, glyph_rows, output ready);
endinterface

interface lcdx_rsp_if import lcdx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] expander_byte;
    logic              last_of_run;
    logic              status;

    modport source (output valid, expander_byte, last_of_run, status, input ready);
    modport sink   (input valid, expander_byte, last_of_run, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcdx_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
// After conversion the digits shift out most significant first, one per command.
// Depends on lcdx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdx_bcd import lcdx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bcd_ctrl_t ctrl,
    output bcd_stat_t      stat
);

    logic                busy_reg;
    logic [BITCNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]    bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    adj;

    // Add three to every digit that is five or more before the next shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Control: busy while the input bits shift in, until the bit counter reaches the last bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == BITCNT_W'(NUM_W - 1))
                busy_reg <= 1'b0;
        end
    end

    // Datapath: binary bits shift into the BCD register, digits shift out at the top.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            bin_reg <= ctrl.value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[NUM_W-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[NUM_W-1]};
        end
        else if (ctrl.shift)
        begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'h0};
        end
    end

    assign stat.done = !busy_reg;
    assign stat.top  = bcd_reg[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ===== rtl/lcdx_seq.sv =====
// Request sequencer: turns one request into a run of logical bytes, four beats each, or a single rejection beat.
// Drives the decimal converter and serialises glyph rows five bits at a time.
// Depends on lcdx_pkg and lcdx_if.
`timescale 1ns / 1ps
`default_nettype none

module lcdx_seq import lcdx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      display_ready,
    lcdx_req_if.sink       req,
    input  wire logic      take,
    input  wire bcd_stat_t bstat,
    output bcd_ctrl_t      bctrl,
    output emit_t          emit
);

    seq_state_t          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [BYTE_W-1:0]   lb_reg, lb_next;
    logic                cmd_reg, cmd_next;
    logic                nr_reg, nr_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [1:0]          phase_reg, phase_next;
    logic [DIGCNT_W-1:0] dig_reg, dig_next;
    logic [ROWS_W-1:0]   rows_reg, rows_next;
    logic                accept;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        lb_next     = lb_reg;
        cmd_next    = cmd_reg;
        nr_next     = nr_reg;
        rem_next    = rem_reg;
        phase_next  = phase_reg;
        dig_next    = dig_reg;
        rows_next   = rows_reg;
        bctrl.start = 1'b0;
        bctrl.shift = 1'b0;
        bctrl.value = req.number_value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = req.mode;
                    nr_next    = !display_ready;
                    rem_next   = '0;
                    phase_next = 2'd0;
                    if (!display_ready)
                    begin
                        // Single rejection beat, marked last.
                        phase_next = 2'd3;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        case (req.mode)
                            MODE_CMD:
                            begin
                                lb_next    = req.value_byte;
                                cmd_next   = 1'b1;
                                state_next = ST_EMIT;
                            end
                            MODE_CHAR:
                            begin
                                lb_next    = req.value_byte;
                                cmd_next   = 1'b0;
                                state_next = ST_EMIT;
                            end
                            MODE_CURSOR:
                            begin
                                lb_next    = (req.cursor_row ? DDRAM_ROW1 : DDRAM_ROW0)
                                             + {2'b00, req.cursor_col};
                                cmd_next   = 1'b1;
                                state_next = ST_EMIT;
                            end
                            MODE_NUMBER:
                            begin
                                bctrl.start = 1'b1;
                                state_next  = ST_CONV;
                            end
                            MODE_GLYPH:
                            begin
                                lb_next    = {CGRAM_TAG, req.glyph_slot, 3'b000};
                                cmd_next   = 1'b1;
                                rows_next  = req.glyph_rows;
                                rem_next   = GLYPH_REM;
                                state_next = ST_EMIT;
                            end
                            default:
                            begin
                                // Unused modes produce nothing.
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            ST_CONV:
            begin
                if (bstat.done)
                begin
                    dig_next   = DIGCNT_W'(DIGITS);
                    state_next = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                // Drop leading zeros one digit a cycle; the units digit always stays.
                bctrl.shift = 1'b1;
                if (bstat.top == 4'h0 && dig_reg != DIGCNT_W'(1))
                begin
                    dig_next = dig_reg - 1'b1;
                end
                else
                begin
                    lb_next    = {ASCII_DIG, bstat.top};
                    cmd_next   = 1'b0;
                    rem_next   = REM_W'(dig_reg - 1'b1);
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (take)
                begin
                    if (phase_reg != 2'd3)
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                    else if (rem_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = 2'd0;
                        rem_next   = rem_reg - 1'b1;
                        if (mode_reg == MODE_NUMBER)
                        begin
                            bctrl.shift = 1'b1;
                            lb_next     = {ASCII_DIG, bstat.top};
                            cmd_next    = 1'b0;
                        end
                        else if (rem_reg == REM_W'(1))
                        begin
                            lb_next  = DDRAM_ROW0;
                            cmd_next = 1'b1;
                        end
                        else
                        begin
                            lb_next   = BYTE_W'(rows_reg[PIX_W-1:0]);
                            cmd_next  = 1'b0;
                            rows_next = rows_reg >> PIX_W;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            phase_reg <= 2'd0;
            nr_reg    <= 1'b0;
            dig_reg   <= '0;
            mode_reg  <= MODE_CMD;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            phase_reg <= phase_next;
            nr_reg    <= nr_next;
            dig_reg   <= dig_next;
            mode_reg  <= mode_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        lb_reg   <= lb_next;
        cmd_reg  <= cmd_next;
        rows_reg <= rows_next;
    end

    assign emit.valid = (state_reg == ST_EMIT);
    assign emit.lb    = lb_reg;
    assign emit.cmd   = cmd_reg;
    assign emit.phase = phase_reg;
    assign emit.last  = (rem_reg == '0) && (phase_reg == 2'd3);
    assign emit.nr    = nr_reg;

endmodule

`default_nettype wire

// ===== rtl/lcdx_out.sv =====
// Output stage: encodes one nibble beat and holds it in the result register.
// Depends on lcdx_pkg and lcdx_if.
`timescale 1ns / 1ps
`default_nettype none

module lcdx_out import lcdx_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire emit_t emit,
    output logic       take,
    lcdx_rsp_if.source rsp
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              status_reg;

    // A beat moves in when the register is empty or is being emptied.
    assign take = emit.valid && (!valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (rsp.ready)
            valid_reg <= 1'b0;
    end

    // A rejected request carries a zero byte.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg   <= emit.nr ? '0 : enc_byte(emit.lb, emit.cmd, emit.phase);
            last_reg   <= emit.last;
            status_reg <= emit.nr;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.expander_byte = byte_reg;
    assign rsp.last_of_run   = last_reg;
    assign rsp.status        = status_reg;

endmodule

`default_nettype wire

// ===== rtl/char_lcd_expander_byte_generator_core.sv =====
// Timing: the first beat passes the sequencer state register and then the output register after accept (modes
//   0-2, 4, not ready); number mode first runs the bit-serial conversion and the leading-zero skip.
// Throughput: one expander beat per cycle while rsp.ready holds; a request makes 1, 4, 4-20 or 40
//   beats (0 for unused modes if ready), after conversion and skip for numbers; one request at a time.
// Reset: asynchronous; clears sequencer and converter control state, the output valid flag and display_ready.
// Depends on lcdx_pkg, lcdx_if, lcdx_bcd, lcdx_seq and lcdx_out.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_expander_byte_generator_core import lcdx_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_wr_en,
    input  wire logic  cfg_wr_data,
    lcdx_req_if.sink   req,
    lcdx_rsp_if.source rsp
);

    logic      display_ready_reg;
    logic      take;
    emit_t     emit;
    bcd_ctrl_t bctrl;
    bcd_stat_t bstat;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            display_ready_reg <= 1'b0;
        else if (cfg_wr_en)
            display_ready_reg <= cfg_wr_data;
    end

    lcdx_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .display_ready (display_ready_reg),
        .req           (req),
        .take          (take),
        .bstat         (bstat),
        .bctrl         (bctrl),
        .emit          (emit)
    );

    lcdx_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (bctrl),
        .stat  (bstat)
    );

    lcdx_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .emit  (emit),
        .take  (take),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/lcdx_checker.sv =====
// Port-level checks on the result stream of the generator, with the bind to the top level.
// Depends on lcdx_pkg and the top level char_lcd_expander_byte_generator_core.
`timescale 1ns / 1ps
`default_nettype none

module lcdx_checker import lcdx_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [BYTE_W-1:0] rsp_byte,
    input wire logic              rsp_last,
    input wire logic              rsp_status
);

    // A rejection is a single zero beat that closes its run.
    a_reject_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_last && rsp_byte == '0)
        else $error("rejection beat is not a lone zero byte");

    // Every beat of an accepted request carries one of the known control patterns.
    a_ctl_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_status |->
            rsp_byte[3:0] == DATA_STROBE || rsp_byte[3:0] == DATA_HOLD ||
            rsp_byte[3:0] == CMD_STROBE  || rsp_byte[3:0] == CMD_HI_HOLD ||
            rsp_byte[3:0] == CMD_LO_HOLD)
        else $error("unknown control pattern on expander byte");

    // The high-nibble hold of a command never ends a run.
    a_hi_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_status && rsp_byte[3:0] == CMD_HI_HOLD |-> !rsp_last)
        else $error("run ends on a high-nibble beat");

    // A stalled beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
        else $error("stalled beat changed");

endmodule

bind char_lcd_expander_byte_generator_core lcdx_checker u_lcdx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_byte   (rsp.expander_byte),
    .rsp_last   (rsp.last_of_run),
    .rsp_status (rsp.status)
);

`default_nettype wire
